// ===== rtl/lsts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsts_pkg: shared types and constants
// Field widths and the transaction token that travels along the cell chain.
// ----------------------------------------------------------------------------
package lsts_pkg;

    localparam int ELEM_W   = 32;
    localparam int SUM_W    = 48;
    localparam int BEST_W   = 9;
    localparam int M_DATA_W = 16;

    // Largest value the best_length field can show.
    localparam logic [BEST_W-1:0] BEST_SAT = {BEST_W{1'b1}};

    // Control and prefix data of one transaction on its way down the chain.
    typedef struct packed {
        logic             valid;  // slot holds a transaction
        logic             first;  // transaction opens a new array
        logic             full;   // transaction was over capacity and is ignored
        logic             done;   // prefix found in, or written to, the table
        logic [SUM_W-1:0] sum;    // running prefix sum after this element
        logic [SUM_W-1:0] need;   // prefix that would close a run with the target sum
    } lsts_tok_t;

endpackage

// ===== rtl/lsts_head.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsts_head: running sum and entry stages
// Holds the target register, the running prefix sum and the position, and
// prepares each transaction for the cell chain over two register stages.
// ----------------------------------------------------------------------------
module lsts_head #(
    parameter int MAX_ITEMS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [lsts_pkg::ELEM_W-1:0]         cfg_wdata,
    input  logic                                advance,
    input  logic                                in_valid,
    input  logic [lsts_pkg::ELEM_W-1:0]         element,
    input  logic                                first,
    output lsts_pkg::lsts_tok_t                 tok_out,
    output logic [$clog2(MAX_ITEMS)-1:0]        pos_out,
    output logic [$clog2(MAX_ITEMS+1)-1:0]      cand_out
);

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int PW = $clog2(MAX_ITEMS + 1);
    localparam int SW = lsts_pkg::SUM_W;
    localparam int EW = lsts_pkg::ELEM_W;

    logic [EW-1:0]        target_sum_reg;
    logic [SW-1:0]        running_sum_reg, running_sum_next;
    logic [PW-1:0]        position_reg, position_next;
    lsts_pkg::lsts_tok_t  st0_tok_reg, st0_tok_next;
    logic [IW-1:0]        st0_pos_reg;
    lsts_pkg::lsts_tok_t  st1_tok_reg, st1_tok_next;
    logic [IW-1:0]        st1_pos_reg;
    logic [PW-1:0]        st1_cand_reg, st1_cand_next;

    logic [SW-1:0]        sum_eff;
    logic [SW-1:0]        sum_new;
    logic [PW-1:0]        pos_eff;
    logic                 over_cap;
    logic [SW-1:0]        target_ext;

    // A new array restarts the sum and position before the element is added.
    always_comb begin
        sum_eff   = first ? '0 : running_sum_reg;
        pos_eff   = first ? '0 : position_reg;
        over_cap  = (pos_eff >= PW'(MAX_ITEMS));
        sum_new   = sum_eff + {{(SW-EW){element[EW-1]}}, element};
        running_sum_next = running_sum_reg;
        position_next    = position_reg;
        if (in_valid && !over_cap) begin
            running_sum_next = sum_new;
            position_next    = pos_eff + PW'(1);
        end
        st0_tok_next       = '0;
        st0_tok_next.valid = in_valid;
        st0_tok_next.first = first;
        st0_tok_next.full  = over_cap;
        st0_tok_next.sum   = sum_new;
    end

    // The second stage works out the prefix to look for and a run from the start.
    always_comb begin
        target_ext         = {{(SW-EW){target_sum_reg[EW-1]}}, target_sum_reg};
        st1_tok_next       = st0_tok_reg;
        st1_tok_next.need  = st0_tok_reg.sum - target_ext;
        st1_tok_next.done  = 1'b0;
        st1_cand_next      = (st0_tok_reg.sum == target_ext)
                           ? (PW'(st0_pos_reg) + PW'(1)) : '0;
    end

    // Control state and the payload of the two entry stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_sum_reg    <= '0;
            running_sum_reg   <= '0;
            position_reg      <= '0;
            st0_tok_reg.valid <= 1'b0;
            st1_tok_reg.valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                target_sum_reg <= cfg_wdata;
            end
            if (advance) begin
                running_sum_reg   <= running_sum_next;
                position_reg      <= position_next;
                st0_tok_reg.valid <= st0_tok_next.valid;
                st1_tok_reg.valid <= st1_tok_next.valid;
            end
        end
        if (advance) begin
            st0_tok_reg.first <= st0_tok_next.first;
            st0_tok_reg.full  <= st0_tok_next.full;
            st0_tok_reg.done  <= st0_tok_next.done;
            st0_tok_reg.sum   <= st0_tok_next.sum;
            st0_tok_reg.need  <= st0_tok_next.need;
            st0_pos_reg       <= pos_eff[IW-1:0];
            st1_tok_reg.first <= st1_tok_next.first;
            st1_tok_reg.full  <= st1_tok_next.full;
            st1_tok_reg.done  <= st1_tok_next.done;
            st1_tok_reg.sum   <= st1_tok_next.sum;
            st1_tok_reg.need  <= st1_tok_next.need;
            st1_pos_reg       <= st0_pos_reg;
            st1_cand_reg      <= st1_cand_next;
        end
    end

    assign tok_out  = st1_tok_reg;
    assign pos_out  = st1_pos_reg;
    assign cand_out = st1_cand_reg;

endmodule

// ===== rtl/lsts_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsts_cell: one prefix table cell
// Holds one distinct prefix sum and its first position, compares it with the
// passing transaction and hands the transaction on to the next cell.
// ----------------------------------------------------------------------------
module lsts_cell #(
    parameter int MAX_ITEMS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  lsts_pkg::lsts_tok_t                 tok_in,
    input  logic [$clog2(MAX_ITEMS)-1:0]        pos_in,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]      cand_in,
    output lsts_pkg::lsts_tok_t                 tok_out,
    output logic [$clog2(MAX_ITEMS)-1:0]        pos_out,
    output logic [$clog2(MAX_ITEMS+1)-1:0]      cand_out
);

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int PW = $clog2(MAX_ITEMS + 1);
    localparam int SW = lsts_pkg::SUM_W;

    logic                 entry_valid_reg, entry_valid_next;
    logic [SW-1:0]        entry_sum_reg;
    logic [IW-1:0]        entry_pos_reg;
    lsts_pkg::lsts_tok_t  tok_reg, tok_next;
    logic [IW-1:0]        pos_reg;
    logic [PW-1:0]        cand_reg, cand_next;

    logic                 live;
    logic                 eff_valid;
    logic                 match_need;
    logic                 match_sum;
    logic                 insert;
    logic [IW-1:0]        run_len;

    // An array's first transaction sees this cell empty and fills or clears it.
    always_comb begin
        live       = tok_in.valid && !tok_in.full;
        eff_valid  = entry_valid_reg && !tok_in.first;
        match_need = live && eff_valid && (entry_sum_reg == tok_in.need);
        match_sum  = live && eff_valid && (entry_sum_reg == tok_in.sum);
        insert     = live && !eff_valid && !tok_in.done;
        run_len    = pos_in - entry_pos_reg;

        cand_next = cand_in;
        if (match_need && (PW'(run_len) > cand_in)) begin
            cand_next = PW'(run_len);
        end

        tok_next      = tok_in;
        tok_next.done = tok_in.done || match_sum || insert;

        entry_valid_next = entry_valid_reg;
        if (insert) begin
            entry_valid_next = 1'b1;
        end else if (live && tok_in.first) begin
            entry_valid_next = 1'b0;
        end
    end

    // Control state, stored prefix and the forwarded transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
            tok_reg.valid   <= 1'b0;
        end else if (advance) begin
            entry_valid_reg <= entry_valid_next;
            tok_reg.valid   <= tok_next.valid;
        end
        if (advance) begin
            if (insert) begin
                entry_sum_reg <= tok_in.sum;
                entry_pos_reg <= pos_in;
            end
            tok_reg.first <= tok_next.first;
            tok_reg.full  <= tok_next.full;
            tok_reg.done  <= tok_next.done;
            tok_reg.sum   <= tok_next.sum;
            tok_reg.need  <= tok_next.need;
            pos_reg       <= pos_in;
            cand_reg      <= cand_next;
        end
    end

    assign tok_out  = tok_reg;
    assign pos_out  = pos_reg;
    assign cand_out = cand_reg;

endmodule

// ===== rtl/lsts_tail.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsts_tail: best length and output register
// Keeps the longest run of the current array and presents one result
// transaction for each transaction that leaves the chain.
// ----------------------------------------------------------------------------
module lsts_tail #(
    parameter int MAX_ITEMS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lsts_pkg::lsts_tok_t                 tok_in,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]      cand_in,
    output logic                                advance,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lsts_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tuser
);

    localparam int PW = $clog2(MAX_ITEMS + 1);
    localparam int BW = lsts_pkg::BEST_W;
    localparam int XW = (PW > BW) ? PW : BW;

    logic [PW-1:0]  best_reg, best_next;
    logic           m_tvalid_reg;
    logic [BW-1:0]  best_out_reg, best_out_next;
    logic           full_out_reg;
    logic [XW-1:0]  best_wide;

    // The whole chain moves whenever the output register can take a result.
    assign advance = !m_tvalid_reg || m_tready;

    // Longest run so far; an ignored transaction leaves it unchanged.
    always_comb begin
        best_next = best_reg;
        if (tok_in.valid && !tok_in.full) begin
            if (tok_in.first || (cand_in > best_reg)) begin
                best_next = cand_in;
            end
        end
        best_wide     = XW'(best_next);
        best_out_next = (best_wide > XW'(lsts_pkg::BEST_SAT))
                      ? lsts_pkg::BEST_SAT : best_wide[BW-1:0];
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            best_reg     <= best_next;
            m_tvalid_reg <= tok_in.valid;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            best_out_reg <= best_out_next;
            full_out_reg <= tok_in.full;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(lsts_pkg::M_DATA_W-BW){1'b0}}, best_out_reg};
    assign m_tuser  = full_out_reg;

endmodule

// ===== rtl/longest_subarray_target_sum.sv =====
`timescale 1ns / 1ps
// Pipeline: two entry stages, one stage per table cell, one output register.
// Throughput: one transaction per cycle while m_tready is high; the cell
// chain is one pipeline that holds as a whole while a result waits.
// Reset: aresetn is synchronous and active low; it clears the target sum,
// the running sum, position, best length and every cell's valid flag.
// ----------------------------------------------------------------------------
// longest_subarray_target_sum: streaming longest run with a given sum
// Keeps the prefix sums of the current array in a chain of comparing cells
// and reports, per element, the longest run whose sum equals the target.
// ----------------------------------------------------------------------------
module longest_subarray_target_sum #(
    parameter int MAX_ITEMS = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration: target_sum, signed.
    input  logic                              cfg_we,
    input  logic [lsts_pkg::ELEM_W-1:0]       cfg_wdata,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lsts_pkg::ELEM_W-1:0]       s_tdata,   // [31:0] element
    input  logic                              s_tuser,   // [0] first
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lsts_pkg::M_DATA_W-1:0]     m_tdata,   // [8:0] best_length, [15:9] zero
    output logic                              m_tuser    // [0] table_full
);

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int PW = $clog2(MAX_ITEMS + 1);

    logic                 advance;
    lsts_pkg::lsts_tok_t  tok  [0:MAX_ITEMS];
    logic [IW-1:0]        pos  [0:MAX_ITEMS];
    logic [PW-1:0]        cand [0:MAX_ITEMS];

    assign s_tready = advance;

    // Running sum and entry stages.
    lsts_head #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_head (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .in_valid  (s_tvalid && advance),
        .element   (s_tdata),
        .first     (s_tuser),
        .tok_out   (tok[0]),
        .pos_out   (pos[0]),
        .cand_out  (cand[0])
    );

    // Chain of prefix table cells, filled from the front.
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        lsts_cell #(
            .MAX_ITEMS (MAX_ITEMS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .tok_in   (tok[g]),
            .pos_in   (pos[g]),
            .cand_in  (cand[g]),
            .tok_out  (tok[g+1]),
            .pos_out  (pos[g+1]),
            .cand_out (cand[g+1])
        );
    end

    // Best length and output register.
    lsts_tail #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_tail (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tok_in   (tok[MAX_ITEMS]),
        .cand_in  (cand[MAX_ITEMS]),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/lsts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsts_checker: port-level checks
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module lsts_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lsts_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                            m_tuser
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result transaction changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Input is taken exactly when the output register can move on.
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output state");

    // Padding bits above best_length stay zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[lsts_pkg::M_DATA_W-1:lsts_pkg::BEST_W] == '0)
        else $error("padding bits of result data set");

endmodule

bind longest_subarray_target_sum lsts_checker u_lsts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for longest_subarray_target_sum
// Streams signed elements into the block, predicts the longest run with the
// target sum for every accepted transaction and compares each result as it
// leaves. It covers directed corner cases, several target settings and
// overfilled arrays, with random input gaps and random result stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CAPACITY       = 256;
    localparam int LATENCY        = CAPACITY + 3;
    localparam int HOLD_AT        = 40;
    localparam int HOLD_CYCLES    = 800;
    localparam int WATCHDOG_LIMIT = 4 * (HOLD_CYCLES + LATENCY + 8);

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [lsts_pkg::ELEM_W-1:0]   cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [lsts_pkg::ELEM_W-1:0]   s_tdata;   // [31:0] element
    logic                          s_tuser;   // [0] first
    logic                          m_tvalid;
    logic                          m_tready;
    logic [lsts_pkg::M_DATA_W-1:0] m_tdata;   // [8:0] best_length, [15:9] zero
    logic                          m_tuser;   // [0] table_full

    // Tracks the prefix sums of the current array and queues the expected
    // best length for every element that the block accepts.
    class longest_run_tracker;
        typedef struct {
            logic [lsts_pkg::BEST_W-1:0] best_length;
            logic                        table_full;
        } run_result_t;

        longint      target_sum;
        longint      prefix_sum;
        int unsigned accepted;
        int unsigned longest;
        int unsigned first_seen[longint];
        run_result_t expected_results[$];
        int unsigned fail_count;

        function new();
            target_sum = 0;
            fail_count = 0;
            clear_array();
        endfunction

        function void clear_array();
            prefix_sum = 0;
            accepted   = 0;
            longest    = 0;
            first_seen.delete();
        endfunction

        function void set_target(logic [lsts_pkg::ELEM_W-1:0] value);
            target_sum = longint'($signed(value));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_element(logic [lsts_pkg::ELEM_W-1:0] element, logic first);
            run_result_t result;
            longint      need;
            result.table_full = 1'b0;
            if (first) begin
                clear_array();
            end
            if (accepted >= CAPACITY) begin
                // Over capacity: the element is dropped and the state is kept.
                result.table_full = 1'b1;
            end else begin
                prefix_sum += longint'($signed(element));
                if (prefix_sum == target_sum && accepted + 1 > longest) begin
                    longest = accepted + 1;
                end
                need = prefix_sum - target_sum;
                if (first_seen.exists(need) && accepted - first_seen[need] > longest) begin
                    longest = accepted - first_seen[need];
                end
                if (!first_seen.exists(prefix_sum)) begin
                    first_seen[prefix_sum] = accepted;
                end
                accepted++;
            end
            result.best_length = (longest > lsts_pkg::BEST_SAT)
                               ? lsts_pkg::BEST_SAT : longest[lsts_pkg::BEST_W-1:0];
            expected_results.push_back(result);
        endfunction

        function void check_result(logic [lsts_pkg::BEST_W-1:0] best_length,
                                   logic table_full);
            run_result_t want;
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected: best_length %0d",
                       best_length);
                fail_count++;
                return;
            end
            want = expected_results.pop_front();
            if (best_length !== want.best_length) begin
                $error("best_length: expected %0d, got %0d", want.best_length, best_length);
                fail_count++;
            end
            if (table_full !== want.table_full) begin
                $error("table_full: expected %0d, got %0d", want.table_full, table_full);
                fail_count++;
            end
        endfunction
    endclass

    longest_run_tracker tracker;
    int                 idle_cycles;

    longest_subarray_target_sum #(
        .MAX_ITEMS (CAPACITY)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Observe every transaction at the rising edge and guard against a hang.
    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles = 0;
        end else begin
            if (cfg_we) begin
                tracker.set_target(cfg_wdata);
            end
            if (s_tvalid && s_tready) begin
                tracker.note_element(s_tdata, s_tuser);
            end
            if (m_tvalid && m_tready) begin
                tracker.check_result(m_tdata[lsts_pkg::BEST_W-1:0], m_tuser);
            end
            if (cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Result side: random stalls, eager stretches and one long hold-off that
    // lets the cell chain fill and push back on the input.
    initial begin : result_sink
        int stall;
        int taken;
        bit eager;
        taken    = 0;
        eager    = 1'b0;
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(negedge aclk);
        forever begin
            if (taken % 64 == 0) begin
                eager = ($urandom_range(0, 2) == 0);
            end
            stall = eager ? 0 : $urandom_range(0, 4);
            if (taken == HOLD_AT) begin
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
            @(negedge aclk);
        end
    end

    // Offer one element after an idle gap and return once it is accepted.
    task automatic push_element(input logic [lsts_pkg::ELEM_W-1:0] element,
                                input logic first, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= element;
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // The target may only change once the block has drained.
    task automatic write_target(input int value);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly small values so that runs hitting a small target are common,
    // with the target itself, its negation and full-range values mixed in.
    function automatic logic [lsts_pkg::ELEM_W-1:0] pick_element(input int target);
        case ($urandom_range(0, 15))
            0:       return $urandom;
            1:       return target;
            2:       return -target;
            default: return $urandom_range(0, 6) - 3;
        endcase
    endfunction

    // A stretch of random arrays under one target; an overfilled phase opens
    // with an array longer than the table, so the next array's first element
    // arrives while the block is over capacity.
    task automatic run_phase(input int target, input int item_budget, input bit overfill);
        int sent;
        int len;
        bit eager;
        write_target(target);
        sent = 0;
        while (sent < item_budget) begin
            len   = (overfill && sent == 0) ? CAPACITY + $urandom_range(4, 30)
                                            : $urandom_range(1, 40);
            eager = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < len; j++) begin
                push_element(pick_element(target), j == 0, eager ? 0 : $urandom_range(0, 4));
            end
            sent += len;
        end
    endtask

    initial begin : stimulus
        tracker   = new();
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Target zero after reset; the first elements arrive before any
        // array has been opened.
        push_element(32'd0, 1'b0, 0);
        push_element(32'd7, 1'b0, 1);
        push_element(-32'sd7, 1'b0, 0);
        push_element(32'h7FFF_FFFF, 1'b1, 2);
        push_element(32'h8000_0000, 1'b0, 0);
        push_element(32'd1, 1'b0, 0);
        push_element(32'hFFFF_FFFF, 1'b1, 3);
        push_element(32'hFFFF_FFFF, 1'b0, 0);
        push_element(32'd2, 1'b0, 4);

        // Largest positive target.
        write_target(32'h7FFF_FFFF);
        push_element(32'h7FFF_FFFF, 1'b1, 0);
        push_element(32'd0, 1'b0, 0);
        push_element(32'h8000_0000, 1'b0, 1);
        push_element(32'h7FFF_FFFF, 1'b0, 0);
        push_element(32'h7FFF_FFFF, 1'b0, 0);
        push_element(32'd1, 1'b1, 2);
        push_element(32'h7FFF_FFFE, 1'b0, 0);

        // Most negative target; the prefix sum grows well past 32 bits.
        write_target(32'h8000_0000);
        push_element(32'h8000_0000, 1'b1, 0);
        push_element(32'h8000_0000, 1'b0, 0);
        push_element(32'h8000_0000, 1'b0, 1);
        push_element(32'h8000_0000, 1'b0, 0);
        push_element(32'h7FFF_FFFF, 1'b0, 0);
        push_element(32'd1, 1'b0, 2);
        push_element(32'h8000_0000, 1'b1, 0);

        // Random phases under small, zero, full-range and again small targets.
        run_phase($urandom_range(0, 8) - 4, 400, 1'b0);
        run_phase(0, 150, 1'b0);
        run_phase($urandom, 150, 1'b0);
        run_phase($urandom_range(0, 8) - 4, 330, 1'b1);
        run_phase($urandom_range(0, 8) - 4, 220, 1'b0);

        // Drain, then give any stray result time to show up.
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (LATENCY + 8) @(negedge aclk);
        if (tracker.fail_count == 0 && tracker.pending() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
